/* hdl/lpht_pkg.sv */
// Shared types and constants for the linear probe hash table unit.
// No dependencies; imported by lpht_slot_ram users and the top level.
package lpht_pkg;

   // Table size; a power of two so the home slot is the low hash bits.
   localparam int SLOT_COUNT = 256;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int USED_W     = IDX_W + 1;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 64;
   localparam int LIMIT_W = 8;

   localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 8'd192;

   typedef enum logic [1:0] {
      MODE_SET    = 2'd0,
      MODE_GET    = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_MISSING = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // One stored slot; emptiness lives in a separate valid vector.
   typedef struct packed {
      logic               tomb;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

/* hdl/lpht_slot_ram.sv */
// Simple dual-port slot memory: one write port, one read port, registered read.
// Generic; no package dependency.
module lpht_slot_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 97
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/linear_probe_hash_table_unit.sv */
// Top level of the linear probe hash table unit.
// Depends on lpht_pkg and lpht_slot_ram.
//
// Usage:
//   req_* beats carry one request (set, get, delete or clear). rsp_* beats
//   return exactly one result per request, in request order. csr_* writes
//   the load limit; it is always ready and should be written only while
//   the unit is idle.
// Probing and ordering:
//   A clear answers straight from idle, with no probe. Any other request
//   probes one slot per cycle (one read of the slot memory per cycle, reads
//   issued back to back) until it finds its key or an empty slot or has
//   visited every slot, so it visits 1 to SLOT_COUNT slots. One request is in
//   flight at a time; a new request is taken once the unit is back in idle
//   and the output register is free or being read out.
// Reset:
//   Synchronous reset empties every slot at once (valid vector cleared),
//   zeroes the used count and loads the limit with 192. No clearing pass.
// Stall:
//   While rsp_ready is low the finished result holds in the output
//   register; a probe that reaches its end holds its read data and waits,
//   and req_ready stays low until the output slot frees.
module linear_probe_hash_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [lpht_pkg::KEY_W-1:0]        req_key_id,
   input  logic [31:0]                       req_key_hash,
   input  logic [lpht_pkg::VALUE_W-1:0]      req_write_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_is_new,
   output logic [lpht_pkg::VALUE_W-1:0]      rsp_read_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpht_pkg::LIMIT_W-1:0]      csr_load_limit
);

   import lpht_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 tomb_seen_ff, tomb_seen_in;
   logic [IDX_W-1:0]     tomb_idx_ff, tomb_idx_in;
   logic [USED_W-1:0]    used_ff, used_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic                 vld_rd_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic                 is_new_ff, is_new_in;
   logic [VALUE_W-1:0]   read_value_ff, read_value_in;

   logic                 out_busy;
   logic                 req_fire;
   logic                 probing;
   logic                 slot_empty, slot_hit, slot_tomb;
   logic                 last_probe, finish, step, done;
   logic                 tomb_any;
   logic [IDX_W-1:0]     tomb_at;
   logic                 room;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   rd_raw;
   slot_entry_type       rd_entry;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   slot_entry_type       wr_entry;

   lpht_slot_ram #(
      .DEPTH(SLOT_COUNT),
      .WIDTH(ENTRY_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = slot_entry_type'(rd_raw);

   // Handshakes: take a request only when idle and the output slot is free
   // (or freeing in this cycle).
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !out_busy;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign probing   = (state_ff == ST_PROBE);

   // Classify the slot whose read data is on hand (address idx_ff).
   assign slot_empty = !vld_rd_ff;
   assign slot_hit   = vld_rd_ff && !rd_entry.tomb && (rd_entry.key == key_ff);
   assign slot_tomb  = vld_rd_ff && rd_entry.tomb;
   assign last_probe = (cnt_ff == IDX_W'(SLOT_COUNT - 1));
   assign finish     = slot_empty || slot_hit || last_probe;
   assign step       = probing && !finish;
   assign done       = probing && finish && !out_busy;

   // First tombstone on the path, counting the slot in hand on the last probe.
   assign tomb_any = tomb_seen_ff || slot_tomb;
   assign tomb_at  = tomb_seen_ff ? tomb_idx_ff : idx_ff;
   assign room     = (USED_W'(used_ff + USED_W'(1))) <= USED_W'(limit_ff);

   // Read the home slot on accepting a non-clear request, then the next slot on each probe step.
   // The read register holds while a finished probe waits on the output.
   assign rd_en   = (req_fire && (mode_type'(req_mode) != MODE_CLEAR)) || step;
   assign rd_addr = probing ? IDX_W'(idx_ff + IDX_W'(1)) : req_key_hash[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      tomb_seen_in  = tomb_seen_ff;
      tomb_idx_in   = tomb_idx_ff;
      used_in       = used_ff;
      limit_in      = limit_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      is_new_in     = is_new_ff;
      read_value_in = read_value_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_entry      = '{tomb: 1'b0, key: key_ff, value: val_ff};

      if (csr_valid) begin
         limit_in = csr_load_limit;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in      = mode_type'(req_mode);
               key_in       = req_key_id;
               val_in       = req_write_value;
               idx_in       = req_key_hash[IDX_W-1:0];
               cnt_in       = '0;
               tomb_seen_in = 1'b0;
               if (mode_type'(req_mode) == MODE_CLEAR) begin
                  // Drop every slot at once and answer right away.
                  valid_in      = '0;
                  used_in       = '0;
                  rsp_valid_in  = 1'b1;
                  status_in     = STATUS_OK;
                  is_new_in     = 1'b0;
                  read_value_in = '0;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (step) begin
               // Advance to the next slot; remember the first tombstone.
               idx_in = IDX_W'(idx_ff + IDX_W'(1));
               cnt_in = IDX_W'(cnt_ff + IDX_W'(1));
               if (slot_tomb && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_idx_in  = idx_ff;
               end
            end else if (done) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               status_in     = STATUS_OK;
               is_new_in     = 1'b0;
               read_value_in = '0;
               case (mode_ff)
                  MODE_SET: begin
                     if (slot_hit) begin
                        wr_en = 1'b1;
                     end else if (tomb_any) begin
                        wr_en     = 1'b1;
                        wr_addr   = tomb_at;
                        is_new_in = 1'b1;
                     end else if (slot_empty && room) begin
                        wr_en             = 1'b1;
                        valid_in[idx_ff]  = 1'b1;
                        used_in           = USED_W'(used_ff + USED_W'(1));
                        is_new_in         = 1'b1;
                     end else begin
                        status_in = STATUS_FULL;
                     end
                  end
                  MODE_GET: begin
                     if (slot_hit) begin
                        read_value_in = rd_entry.value;
                     end else begin
                        status_in = STATUS_MISSING;
                     end
                  end
                  MODE_DELETE: begin
                     if (slot_hit) begin
                        // Rewrite the entry in place with the tombstone mark.
                        wr_en    = 1'b1;
                        wr_entry = '{tomb: 1'b1, key: rd_entry.key,
                                     value: rd_entry.value};
                     end else begin
                        status_in = STATUS_MISSING;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         limit_ff     <= LOAD_LIMIT_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tomb_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tomb_seen_ff <= tomb_seen_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      tomb_idx_ff   <= tomb_idx_in;
      status_ff     <= status_in;
      is_new_ff     <= is_new_in;
      read_value_ff <= read_value_in;
      if (rd_en) begin
         vld_rd_ff <= valid_ff[rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_is_new     = is_new_ff;
   assign rsp_read_value = read_value_ff;

endmodule
